// ===== rtl/hbs_pkg.sv =====
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared constants, register indexes and stage structs of the heightmap
// bilinear sampler.
// ----------------------------------------------------------------------------
package hbs_pkg;

    localparam int MAX_COLS = 256;
    localparam int MAX_ROWS = 256;

    // index widths, at least two bits so a bank half-index exists
    localparam int COL_W = (MAX_COLS > 4) ? $clog2(MAX_COLS) : 2;
    localparam int ROW_W = (MAX_ROWS > 4) ? $clog2(MAX_ROWS) : 2;

    // widths that can hold the cell counts themselves
    localparam int CCNT_W = $clog2(MAX_COLS + 1);
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);

    // four banks split by row and column parity
    localparam int BANK_AW    = (COL_W - 1) + (ROW_W - 1);
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int NUM_BANKS  = 4;

    localparam int HEIGHT_W = 32;
    localparam int FRAC_W   = 16;

    localparam logic signed [HEIGHT_W-1:0] VOID_HEIGHT = -32'sd3276800;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_STEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 3'd4;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic signed [HEIGHT_W-1:0] origin_x;
        logic signed [HEIGHT_W-1:0] origin_z;
        logic [HEIGHT_W-1:0]        inverse_step;
        logic [CCNT_W-1:0]          cols;
        logic [RCNT_W-1:0]          rows;
    } cfg_t;

    typedef struct packed {
        logic                is_query;
        logic                no_grid;
        logic [COL_W-1:0]    ix;
        logic [ROW_W-1:0]    iz;
        logic [FRAC_W-1:0]   fx;
        logic [FRAC_W-1:0]   fz;
        logic [7:0]          col;
        logic [7:0]          row;
        logic [HEIGHT_W-1:0] height;
    } coord_item_t;

    typedef struct packed {
        logic signed [HEIGHT_W-1:0] h00;
        logic signed [HEIGHT_W-1:0] h10;
        logic signed [HEIGHT_W-1:0] h01;
        logic signed [HEIGHT_W-1:0] h11;
        logic [FRAC_W-1:0]          fx;
        logic [FRAC_W-1:0]          fz;
        logic                       no_grid;
    } corner_t;

endpackage

// ===== rtl/hbs_ram.sv =====
// ----------------------------------------------------------------------------
// hbs_ram
// Generic simple dual-port RAM, one write port and one read port with
// registered read data held while the read enable is low.
// ----------------------------------------------------------------------------
module hbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/hbs_coord.sv =====
// ----------------------------------------------------------------------------
// hbs_coord
// Three-stage front end: offset from origin, scale by the reciprocal step,
// clamp to the grid and split into cell index and fraction.
// ----------------------------------------------------------------------------
module hbs_coord
    import hbs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                up_valid,
    output logic                up_ready,
    input  logic                operation,
    input  logic [7:0]          entry_col,
    input  logic [7:0]          entry_row,
    input  logic [HEIGHT_W-1:0] entry_height,
    input  logic [HEIGHT_W-1:0] query_x,
    input  logic [HEIGHT_W-1:0] query_z,
    output logic                down_valid,
    input  logic                down_ready,
    output coord_item_t         item
);

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic acc1, acc2, acc3;

    // stage 1 payload
    logic                     s1_op_reg;
    logic                     s1_ng_reg;
    logic [7:0]               s1_col_reg;
    logic [7:0]               s1_row_reg;
    logic [HEIGHT_W-1:0]      s1_height_reg;
    logic signed [HEIGHT_W:0] s1_dx_reg;
    logic signed [HEIGHT_W:0] s1_dz_reg;
    logic signed [HEIGHT_W:0] s1_dx_next;
    logic signed [HEIGHT_W:0] s1_dz_next;
    logic                     s1_ng_next;

    // stage 2 payload
    logic                      s2_op_reg;
    logic                      s2_ng_reg;
    logic [7:0]                s2_col_reg;
    logic [7:0]                s2_row_reg;
    logic [HEIGHT_W-1:0]       s2_height_reg;
    logic [2*HEIGHT_W-1:0]     s2_gx_reg;
    logic [2*HEIGHT_W-1:0]     s2_gz_reg;
    logic [2*HEIGHT_W-1:0]     s2_gx_next;
    logic [2*HEIGHT_W-1:0]     s2_gz_next;

    // stage 3 clamp
    localparam int G_W = 2 * HEIGHT_W - FRAC_W;
    logic [G_W-1:0]           gx_raw, gz_raw, gx_cl, gz_cl;
    logic [CCNT_W+FRAC_W-1:0] x_limit;
    logic [RCNT_W+FRAC_W-1:0] z_limit;
    coord_item_t              s3_item_reg;
    coord_item_t              s3_item_next;

    assign acc3     = !s3_valid_reg || down_ready;
    assign acc2     = !s2_valid_reg || acc3;
    assign acc1     = !s1_valid_reg || acc2;
    assign up_ready = acc1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc1)
            begin
                s1_valid_reg <= up_valid;
            end
            if (acc2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (acc3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // stage 1: exact 33-bit offsets
    always_comb
    begin
        s1_dx_next = $signed({query_x[HEIGHT_W-1], query_x})
                   - $signed({cfg.origin_x[HEIGHT_W-1], cfg.origin_x});
        s1_dz_next = $signed({query_z[HEIGHT_W-1], query_z})
                   - $signed({cfg.origin_z[HEIGHT_W-1], cfg.origin_z});
        s1_ng_next = (cfg.cols < CCNT_W'(2)) || (cfg.rows < RCNT_W'(2));
    end

    always_ff @(posedge clk)
    begin
        if (acc1)
        begin
            s1_op_reg     <= operation;
            s1_ng_reg     <= s1_ng_next;
            s1_col_reg    <= entry_col;
            s1_row_reg    <= entry_row;
            s1_height_reg <= entry_height;
            s1_dx_reg     <= s1_dx_next;
            s1_dz_reg     <= s1_dz_next;
        end
    end

    // stage 2: scale, offsets at or below zero map to zero
    always_comb
    begin
        if (!s1_dx_reg[HEIGHT_W] && (s1_dx_reg != '0))
        begin
            s2_gx_next = (2*HEIGHT_W)'(s1_dx_reg[HEIGHT_W-1:0])
                       * (2*HEIGHT_W)'(cfg.inverse_step);
        end
        else
        begin
            s2_gx_next = '0;
        end
        if (!s1_dz_reg[HEIGHT_W] && (s1_dz_reg != '0))
        begin
            s2_gz_next = (2*HEIGHT_W)'(s1_dz_reg[HEIGHT_W-1:0])
                       * (2*HEIGHT_W)'(cfg.inverse_step);
        end
        else
        begin
            s2_gz_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc2)
        begin
            s2_op_reg     <= s1_op_reg;
            s2_ng_reg     <= s1_ng_reg;
            s2_col_reg    <= s1_col_reg;
            s2_row_reg    <= s1_row_reg;
            s2_height_reg <= s1_height_reg;
            s2_gx_reg     <= s2_gx_next;
            s2_gz_reg     <= s2_gz_next;
        end
    end

    // stage 3: clamp to one lsb below the last cell
    always_comb
    begin
        gx_raw  = s2_gx_reg[2*HEIGHT_W-1:FRAC_W];
        gz_raw  = s2_gz_reg[2*HEIGHT_W-1:FRAC_W];
        x_limit = {cfg.cols - CCNT_W'(1), {FRAC_W{1'b0}}};
        z_limit = {cfg.rows - RCNT_W'(1), {FRAC_W{1'b0}}};

        if (s2_ng_reg)
        begin
            gx_cl = '0;
        end
        else if (gx_raw >= G_W'(x_limit))
        begin
            gx_cl = G_W'(x_limit) - G_W'(1);
        end
        else
        begin
            gx_cl = gx_raw;
        end

        if (s2_ng_reg)
        begin
            gz_cl = '0;
        end
        else if (gz_raw >= G_W'(z_limit))
        begin
            gz_cl = G_W'(z_limit) - G_W'(1);
        end
        else
        begin
            gz_cl = gz_raw;
        end

        s3_item_next.is_query = (s2_op_reg == OP_QUERY);
        s3_item_next.no_grid  = s2_ng_reg;
        s3_item_next.ix       = gx_cl[FRAC_W +: COL_W];
        s3_item_next.iz       = gz_cl[FRAC_W +: ROW_W];
        s3_item_next.fx       = gx_cl[FRAC_W-1:0];
        s3_item_next.fz       = gz_cl[FRAC_W-1:0];
        s3_item_next.col      = s2_col_reg;
        s3_item_next.row      = s2_row_reg;
        s3_item_next.height   = s2_height_reg;
    end

    always_ff @(posedge clk)
    begin
        if (acc3)
        begin
            s3_item_reg <= s3_item_next;
        end
    end

    assign down_valid = s3_valid_reg;
    assign item       = s3_item_reg;

endmodule

// ===== rtl/hbs_grid.sv =====
// ----------------------------------------------------------------------------
// hbs_grid
// Height store in four banks by row and column parity, so the four
// neighbors of a cell come out of four different banks in the same cycle.
// ----------------------------------------------------------------------------
module hbs_grid
    import hbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        up_valid,
    output logic        up_ready,
    input  coord_item_t item,
    output logic        down_valid,
    input  logic        down_ready,
    output corner_t     corners
);

    logic                acc4;
    logic                fire;
    logic                load_ok;
    logic [ROW_W-1:0]    iz_p1;
    logic [COL_W-1:0]    ix_p1;
    logic [COL_W-1:0]    wcol;
    logic [ROW_W-1:0]    wrow;
    logic [BANK_AW-1:0]  waddr;
    logic [HEIGHT_W-1:0] rdata [NUM_BANKS];

    logic              s4_valid_reg;
    logic              s4_rsel_reg;
    logic              s4_csel_reg;
    logic [FRAC_W-1:0] s4_fx_reg;
    logic [FRAC_W-1:0] s4_fz_reg;
    logic              s4_ng_reg;

    assign acc4     = !s4_valid_reg || down_ready;
    assign up_ready = acc4;
    assign fire     = up_valid && acc4;

    // loads outside the store are dropped
    assign load_ok = (int'(item.col) < MAX_COLS) && (int'(item.row) < MAX_ROWS);
    assign wcol    = COL_W'(item.col);
    assign wrow    = ROW_W'(item.row);
    assign waddr   = {wrow[ROW_W-1:1], wcol[COL_W-1:1]};
    assign iz_p1   = item.iz + ROW_W'(1);
    assign ix_p1   = item.ix + COL_W'(1);

    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        localparam logic RPAR = 1'(b >> 1);
        localparam logic CPAR = 1'(b);

        logic [ROW_W-1:0]   rrow;
        logic [COL_W-1:0]   rcol;
        logic [BANK_AW-1:0] raddr;
        logic               we;
        logic               re;

        // the neighbor row or column that has this parity
        assign rrow  = (item.iz[0] == RPAR) ? item.iz : iz_p1;
        assign rcol  = (item.ix[0] == CPAR) ? item.ix : ix_p1;
        assign raddr = {rrow[ROW_W-1:1], rcol[COL_W-1:1]};
        assign re    = fire && item.is_query;
        assign we    = fire && !item.is_query && load_ok
                    && (wrow[0] == RPAR) && (wcol[0] == CPAR);

        hbs_ram #(
            .WIDTH (HEIGHT_W),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (we),
            .waddr (waddr),
            .wdata (item.height),
            .re    (re),
            .raddr (raddr),
            .rdata (rdata[b])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (acc4)
        begin
            // loads end here
            s4_valid_reg <= up_valid && item.is_query;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s4_rsel_reg <= item.iz[0];
            s4_csel_reg <= item.ix[0];
            s4_fx_reg   <= item.fx;
            s4_fz_reg   <= item.fz;
            s4_ng_reg   <= item.no_grid;
        end
    end

    always_comb
    begin
        corners.h00     = rdata[{s4_rsel_reg, s4_csel_reg}];
        corners.h10     = rdata[{s4_rsel_reg, !s4_csel_reg}];
        corners.h01     = rdata[{!s4_rsel_reg, s4_csel_reg}];
        corners.h11     = rdata[{!s4_rsel_reg, !s4_csel_reg}];
        corners.fx      = s4_fx_reg;
        corners.fz      = s4_fz_reg;
        corners.no_grid = s4_ng_reg;
    end

    assign down_valid = s4_valid_reg;

endmodule

// ===== rtl/hbs_lerp.sv =====
// ----------------------------------------------------------------------------
// hbs_lerp
// Four-stage bilinear blend: two column lerps, then one row lerp, each
// lerp a multiply stage followed by a floor-shift and add stage.
// ----------------------------------------------------------------------------
module hbs_lerp
    import hbs_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       up_valid,
    output logic                       up_ready,
    input  corner_t                    corners,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic signed [HEIGHT_W-1:0] sampled_height,
    output logic                       no_grid
);

    localparam int D_W = HEIGHT_W + 1;
    localparam int P_W = D_W + FRAC_W + 1;

    logic acc5, acc6, acc7, acc8;
    logic s5_valid_reg, s6_valid_reg, s7_valid_reg, s8_valid_reg;

    logic signed [D_W-1:0]      d0, d1, d2;
    logic signed [FRAC_W:0]     fxs, fzs;

    logic signed [P_W-1:0]      s5_p0_reg, s5_p1_reg, s5_p0_next, s5_p1_next;
    logic signed [HEIGHT_W-1:0] s5_a0_reg, s5_a1_reg;
    logic [FRAC_W-1:0]          s5_fz_reg;
    logic                       s5_ng_reg;

    logic signed [HEIGHT_W-1:0] s6_h0_reg, s6_h1_reg, s6_h0_next, s6_h1_next;
    logic [FRAC_W-1:0]          s6_fz_reg;
    logic                       s6_ng_reg;

    logic signed [P_W-1:0]      s7_p_reg, s7_p_next;
    logic signed [HEIGHT_W-1:0] s7_a_reg;
    logic                       s7_ng_reg;

    logic signed [HEIGHT_W-1:0] s8_h_reg, s8_h_next;
    logic                       s8_ng_reg;

    assign acc8     = !s8_valid_reg || !result_stall;
    assign acc7     = !s7_valid_reg || acc8;
    assign acc6     = !s6_valid_reg || acc7;
    assign acc5     = !s5_valid_reg || acc6;
    assign up_ready = acc5;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc5)
            begin
                s5_valid_reg <= up_valid;
            end
            if (acc6)
            begin
                s6_valid_reg <= s5_valid_reg;
            end
            if (acc7)
            begin
                s7_valid_reg <= s6_valid_reg;
            end
            if (acc8)
            begin
                s8_valid_reg <= s7_valid_reg;
            end
        end
    end

    // column lerp products
    always_comb
    begin
        fxs        = $signed({1'b0, corners.fx});
        d0         = D_W'(corners.h10) - D_W'(corners.h00);
        d1         = D_W'(corners.h11) - D_W'(corners.h01);
        s5_p0_next = P_W'(d0) * P_W'(fxs);
        s5_p1_next = P_W'(d1) * P_W'(fxs);
    end

    always_ff @(posedge clk)
    begin
        if (acc5)
        begin
            s5_p0_reg <= s5_p0_next;
            s5_p1_reg <= s5_p1_next;
            s5_a0_reg <= corners.h00;
            s5_a1_reg <= corners.h01;
            s5_fz_reg <= corners.fz;
            s5_ng_reg <= corners.no_grid;
        end
    end

    // arithmetic shift floors toward minus infinity; result stays between a and b
    always_comb
    begin
        s6_h0_next = s5_a0_reg + HEIGHT_W'(s5_p0_reg >>> FRAC_W);
        s6_h1_next = s5_a1_reg + HEIGHT_W'(s5_p1_reg >>> FRAC_W);
    end

    always_ff @(posedge clk)
    begin
        if (acc6)
        begin
            s6_h0_reg <= s6_h0_next;
            s6_h1_reg <= s6_h1_next;
            s6_fz_reg <= s5_fz_reg;
            s6_ng_reg <= s5_ng_reg;
        end
    end

    // row lerp product
    always_comb
    begin
        fzs       = $signed({1'b0, s6_fz_reg});
        d2        = D_W'(s6_h1_reg) - D_W'(s6_h0_reg);
        s7_p_next = P_W'(d2) * P_W'(fzs);
    end

    always_ff @(posedge clk)
    begin
        if (acc7)
        begin
            s7_p_reg  <= s7_p_next;
            s7_a_reg  <= s6_h0_reg;
            s7_ng_reg <= s6_ng_reg;
        end
    end

    always_comb
    begin
        if (s7_ng_reg)
        begin
            s8_h_next = VOID_HEIGHT;
        end
        else
        begin
            s8_h_next = s7_a_reg + HEIGHT_W'(s7_p_reg >>> FRAC_W);
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc8)
        begin
            s8_h_reg  <= s8_h_next;
            s8_ng_reg <= s7_ng_reg;
        end
    end

    assign result_valid   = s8_valid_reg;
    assign sampled_height = s8_h_reg;
    assign no_grid        = s8_ng_reg;

endmodule

// ===== rtl/heightmap_bilinear_sampler.sv =====
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler
// Bilinear height lookup over a grid of signed Q16.16 heights.
//
// One item is taken every cycle while item_stall is low, loads and queries
// mixed freely. A query gives its result from the last lerp stage; a load
// writes its entry to a bank and gives no result. The rate is set by the
// grid store, which sits in four banks split by row and column parity so
// the four neighbors of a query are read from four single-port-read banks
// in the same cycle, and loads and queries pass the banks in item order.
// Grid entries are not cleared at reset, so there is no start-up pass, and
// entries read by a query must have been loaded first. A stall on the
// result side backs up through the stages, filling gaps before the item
// side sees a stall.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler
    import hbs_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [HEIGHT_W-1:0]        cfg_data,

    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic                       operation,
    input  logic [7:0]                 entry_col,
    input  logic [7:0]                 entry_row,
    input  logic signed [HEIGHT_W-1:0] entry_height,
    input  logic signed [HEIGHT_W-1:0] query_x,
    input  logic signed [HEIGHT_W-1:0] query_z,

    output logic                       result_valid,
    input  logic                       result_stall,
    output logic signed [HEIGHT_W-1:0] sampled_height,
    output logic                       no_grid
);

    logic signed [HEIGHT_W-1:0] origin_x_reg;
    logic signed [HEIGHT_W-1:0] origin_z_reg;
    logic [HEIGHT_W-1:0]        inverse_step_reg;
    logic [CCNT_W-1:0]          cols_reg, cols_next;
    logic [RCNT_W-1:0]          rows_reg, rows_next;
    cfg_t                       cfg;

    logic        item_ready;
    logic        coord_valid, grid_ready;
    coord_item_t coord_item;
    logic        grid_valid, lerp_ready;
    corner_t     corners;

    assign cfg_ready = 1'b1;

    // counts above the store size saturate
    always_comb
    begin
        if (int'(cfg_data[8:0]) > MAX_COLS)
        begin
            cols_next = CCNT_W'(MAX_COLS);
        end
        else
        begin
            cols_next = CCNT_W'(cfg_data[8:0]);
        end
        if (int'(cfg_data[8:0]) > MAX_ROWS)
        begin
            rows_next = RCNT_W'(MAX_ROWS);
        end
        else
        begin
            rows_next = RCNT_W'(cfg_data[8:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg     <= '0;
            origin_z_reg     <= '0;
            inverse_step_reg <= HEIGHT_W'(65536);
            cols_reg         <= '0;
            rows_reg         <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ORIGIN_X:     origin_x_reg     <= cfg_data;
                CFG_ORIGIN_Z:     origin_z_reg     <= cfg_data;
                CFG_INVERSE_STEP: inverse_step_reg <= cfg_data;
                CFG_GRID_COLS:    cols_reg         <= cols_next;
                CFG_GRID_ROWS:    rows_reg         <= rows_next;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        cfg.origin_x     = origin_x_reg;
        cfg.origin_z     = origin_z_reg;
        cfg.inverse_step = inverse_step_reg;
        cfg.cols         = cols_reg;
        cfg.rows         = rows_reg;
    end

    assign item_stall = !item_ready;

    hbs_coord u_coord (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .up_valid     (item_valid),
        .up_ready     (item_ready),
        .operation    (operation),
        .entry_col    (entry_col),
        .entry_row    (entry_row),
        .entry_height (entry_height),
        .query_x      (query_x),
        .query_z      (query_z),
        .down_valid   (coord_valid),
        .down_ready   (grid_ready),
        .item         (coord_item)
    );

    hbs_grid u_grid (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (coord_valid),
        .up_ready   (grid_ready),
        .item       (coord_item),
        .down_valid (grid_valid),
        .down_ready (lerp_ready),
        .corners    (corners)
    );

    hbs_lerp u_lerp (
        .clk            (clk),
        .rst_n          (rst_n),
        .up_valid       (grid_valid),
        .up_ready       (lerp_ready),
        .corners        (corners),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .sampled_height (sampled_height),
        .no_grid        (no_grid)
    );

endmodule

// ===== rtl/hbs_checker.sv =====
// ----------------------------------------------------------------------------
// hbs_checker
// Port-level checks of the sampler: result channel behavior and result
// count against accepted queries.
// ----------------------------------------------------------------------------
module hbs_checker
    import hbs_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       item_valid,
    input logic                       item_stall,
    input logic                       operation,
    input logic                       result_valid,
    input logic                       result_stall,
    input logic signed [HEIGHT_W-1:0] sampled_height,
    input logic                       no_grid
);

    localparam int PIPE_DEPTH = 8;
    localparam int CNT_W      = $clog2(PIPE_DEPTH + 2);

    logic             query_beat;
    logic             result_beat;
    logic [CNT_W-1:0] pending_reg, pending_next;

    assign query_beat  = item_valid && !item_stall && (operation == OP_QUERY);
    assign result_beat = result_valid && !result_stall;

    always_comb
    begin
        pending_next = pending_reg;
        if (query_beat && !result_beat)
        begin
            pending_next = pending_reg + CNT_W'(1);
        end
        else if (!query_beat && result_beat)
        begin
            pending_next = pending_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result beat dropped while stalled");

    a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(sampled_height) && $stable(no_grid))
        else $error("result payload changed while stalled");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg != '0)
        else $error("result without an accepted query");

    // a full pipe only takes a query in the cycle a result leaves
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        query_beat && !result_beat |-> pending_reg < CNT_W'(PIPE_DEPTH))
        else $error("more queries in flight than stages");

    a_void: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && no_grid |-> sampled_height == VOID_HEIGHT)
        else $error("no-grid result without void height");

endmodule

bind heightmap_bilinear_sampler hbs_checker u_hbs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .operation      (operation),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .sampled_height (sampled_height),
    .no_grid        (no_grid)
);
